// ===== sv/glyph_index_mapper_top_macros.svh =====
// Assertion macros used by the glyph index mapper engine
`ifndef GLYPH_INDEX_MAPPER_TOP_MACROS_SVH
`define GLYPH_INDEX_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset
`define GIM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define GIM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/gim_pkg.sv =====
// Package: constants, types and codes of the glyph index mapper
`timescale 1ns / 1ps
package gim_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int CODE_W      = 16;
   localparam int SLOT_W      = 8;
   localparam int IDX_W       = 14;
   localparam int CNT_FIELD_W = 9;
   localparam int PADDR_W     = 4;
   localparam int PDATA_W     = 32;

   localparam logic [CODE_W-1:0] ASCII_LO  = 16'h0020;
   localparam logic [CODE_W-1:0] ASCII_HI  = 16'h007E;
   localparam logic [CODE_W-1:0] HANGUL_LO = 16'hAC00;
   localparam logic [CODE_W-1:0] HANGUL_HI = 16'hD7A3;

   localparam logic [IDX_W-1:0] ASCII_SPAN  = IDX_W'(ASCII_HI - ASCII_LO + 16'd1);
   localparam logic [IDX_W-1:0] HANGUL_SPAN = IDX_W'(HANGUL_HI - HANGUL_LO + 16'd1);

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_WRITE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      REG_ASCII  = 2'd0,
      REG_HANGUL = 2'd1,
      REG_COUNT  = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SRCH,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                   ascii_enable;
      logic                   hangul_enable;
      logic [CNT_FIELD_W-1:0] extra_count;
   } cfg_type;

endpackage

// ===== sv/gim_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps
module gim_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/gim_csr.sv =====
// Configuration registers behind the APB-style port
`timescale 1ns / 1ps
module gim_csr
   import gim_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   logic                   ascii_en_ff;
   logic                   ascii_en_in;
   logic                   hangul_en_ff;
   logic                   hangul_en_in;
   logic [CNT_FIELD_W-1:0] count_ff;
   logic [CNT_FIELD_W-1:0] count_in;
   logic                   wr_strobe;

   assign pready    = 1'b1;
   assign wr_strobe = psel & penable & pwrite;

   always_comb begin
      ascii_en_in  = ascii_en_ff;
      hangul_en_in = hangul_en_ff;
      count_in     = count_ff;
      if (wr_strobe) begin
         unique case (paddr[3:2])
            REG_ASCII:  ascii_en_in  = pwdata[0];
            REG_HANGUL: hangul_en_in = pwdata[0];
            REG_COUNT:  count_in     = pwdata[CNT_FIELD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ascii_en_ff  <= 1'b1;
         hangul_en_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         ascii_en_ff  <= ascii_en_in;
         hangul_en_ff <= hangul_en_in;
         count_ff     <= count_in;
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_ASCII:  prdata = PDATA_W'(ascii_en_ff);
         REG_HANGUL: prdata = PDATA_W'(hangul_en_ff);
         REG_COUNT:  prdata = PDATA_W'(count_ff);
         default:    prdata = '0;
      endcase
   end

   assign cfg.ascii_enable  = ascii_en_ff;
   assign cfg.hangul_enable = hangul_en_ff;
   assign cfg.extra_count   = count_ff;

endmodule

// ===== sv/gim_engine.sv =====
// Lookup engine: range checks and binary search over the extra code RAM
`timescale 1ns / 1ps
`include "glyph_index_mapper_top_macros.svh"
module gim_engine
   import gim_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [CODE_W-1:0] req_code,
   input  logic [SLOT_W-1:0] req_slot,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_glyph_index,
   output logic              rsp_found
);

   state_type            state_ff, state_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [IDX_W-1:0]     base_ff, base_in;
   logic [COUNT_W-1:0]   first_ff, first_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]     res_index_ff, res_index_in;
   logic                 res_found_ff, res_found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic                 rsp_found_ff, rsp_found_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [CODE_W-1:0]    rd_data;

   logic                 ascii_hit;
   logic                 hangul_hit;
   logic [IDX_W-1:0]     base_ascii;
   logic [IDX_W-1:0]     base_full;
   logic [COUNT_W-1:0]   n_sat;
   logic [COUNT_W-1:0]   step;
   logic [COUNT_W-1:0]   at_pos;
   logic [COUNT_W-1:0]   nfirst;
   logic [COUNT_W-1:0]   ncount;
   logic [COUNT_W-1:0]   nat;
   logic                 lt;

   // One item in flight at a time, so a table write never overlaps a search read
   gim_ram #(
      .DATA_W (CODE_W),
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_code),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      ascii_hit  = cfg.ascii_enable && (req_code >= ASCII_LO) && (req_code <= ASCII_HI);
      hangul_hit = cfg.hangul_enable && (req_code >= HANGUL_LO) && (req_code <= HANGUL_HI);
      base_ascii = cfg.ascii_enable ? ASCII_SPAN : '0;
      base_full  = base_ascii + (cfg.hangul_enable ? HANGUL_SPAN : IDX_W'(0));
      if (32'(cfg.extra_count) > TABLE_DEPTH) begin
         n_sat = COUNT_W'(TABLE_DEPTH);
      end else begin
         n_sat = COUNT_W'(cfg.extra_count);
      end
   end

   // One halving step of the lower-bound search on the word read last cycle
   always_comb begin
      lt     = rd_data < code_ff;
      step   = count_ff >> 1;
      at_pos = first_ff + step;
      if (lt) begin
         nfirst = at_pos + COUNT_W'(1);
         ncount = count_ff - step - COUNT_W'(1);
      end else begin
         nfirst = first_ff;
         ncount = step;
      end
      nat = nfirst + (ncount >> 1);
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      base_in      = base_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      res_index_in = res_index_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_found_in = rsp_found_ff;
      wr_en        = 1'b0;
      wr_addr      = req_slot[ADDR_W-1:0];
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               code_in      = req_code;
               base_in      = base_full;
               first_in     = '0;
               count_in     = n_sat;
               n_in         = n_sat;
               res_index_in = '0;
               res_found_in = 1'b0;
               state_in     = ST_FINISH;
               if (req_opcode == OP_WRITE) begin
                  wr_en = (32'(req_slot) < TABLE_DEPTH);
               end else if (ascii_hit) begin
                  res_index_in = IDX_W'(req_code - ASCII_LO);
                  res_found_in = 1'b1;
               end else if (hangul_hit) begin
                  res_index_in = base_ascii + IDX_W'(req_code - HANGUL_LO);
                  res_found_in = 1'b1;
               end else if (n_sat != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = ADDR_W'(n_sat >> 1);
                  state_in = ST_SRCH;
               end
            end
         end
         ST_SRCH: begin
            first_in = nfirst;
            count_in = ncount;
            rd_en    = 1'b1;
            if (ncount == '0) begin
               // fetch the lower-bound entry for the equality check
               rd_addr  = nfirst[ADDR_W-1:0];
               state_in = ST_CHECK;
            end else begin
               rd_addr = nat[ADDR_W-1:0];
            end
         end
         ST_CHECK: begin
            res_found_in = (first_ff < n_ff) && (rd_data == code_ff);
            res_index_in = (first_ff < n_ff) && (rd_data == code_ff) ?
                           base_ff + IDX_W'(first_ff) : '0;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output word is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = res_index_ff;
               rsp_found_in = res_found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      base_ff      <= base_in;
      first_ff     <= first_in;
      count_ff     <= count_in;
      n_ff         <= n_in;
      res_index_ff <= res_index_in;
      res_found_ff <= res_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_glyph_index = rsp_index_ff;
   assign rsp_found       = rsp_found_ff;

   `GIM_ASSERT_NOW(a_srch_count, state_ff == ST_SRCH, count_ff != '0, "search with empty span")
   `GIM_ASSERT_NOW(a_srch_bound, state_ff == ST_SRCH, (first_ff + count_ff) <= n_ff, "search span beyond table count")
   `GIM_ASSERT_NOW(a_miss_zero, rsp_valid_ff && !rsp_found_ff, rsp_index_ff == '0, "miss with nonzero index")
   `GIM_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_ff != ST_IDLE, "accepted word left no work")

endmodule

// ===== sv/glyph_index_mapper_top.sv =====
// Flow: a write or a range hit goes from the accept straight to the FINISH state;
// a table search runs one halving step per RAM read in SRCH, then the final
// compare in CHECK, then FINISH, which holds until the output register is free.
// A new word is taken once the previous one has moved to the output register.
// Reset (synchronous, active high) clears control state and the registers to
// ascii 1, hangul 0, count 0; the code table stays undefined until written.
`timescale 1ns / 1ps
module glyph_index_mapper_top
   import gim_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [CODE_W-1:0]  req_code,
   input  logic [SLOT_W-1:0]  req_slot,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [IDX_W-1:0]   rsp_glyph_index,
   output logic               rsp_found,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   cfg_type cfg;

   gim_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gim_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_code        (req_code),
      .req_slot        (req_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_glyph_index (rsp_glyph_index),
      .rsp_found       (rsp_found)
   );

endmodule
